FILE: rtl/umepe_pkg.sv
// Shared types and constants for the USB-MIDI event packet encoder.
// No dependencies; imported by the output stage and the top level.
`timescale 1ns / 1ps

package umepe_pkg;

    // Code index numbers that change how a message is framed.
    localparam logic [3:0] CIN_PROG_CHANGE = 4'hC;
    localparam logic [3:0] CIN_CHAN_PRESS  = 4'hD;
    localparam logic [3:0] CIN_SYSTEM      = 4'hF;

    // Width of the packed output tdata: four fields padded to whole bytes.
    localparam int unsigned OUT_TDATA_W = 32;

    // Data bytes still expected for the open message.
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_ONE  = 2'd1,
        PEND_TWO  = 2'd2
    } t_pend;

    // One result item as it travels to the output stage.
    typedef struct packed {
        logic       has_packet;
        logic [3:0] code_index;
        logic [7:0] status_byte;
        logic [7:0] data_one;
        logic [7:0] data_two;
        logic       transfer_end;
    } t_result;

endpackage

FILE: rtl/umepe_out_stage.sv
// Output register with a skid entry for the encoder's result stream.
// Depends on umepe_pkg for the result item type.
`timescale 1ns / 1ps

module umepe_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  umepe_pkg::t_result i_item,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_pop_ready,
    output umepe_pkg::t_result o_item
);
    import umepe_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid && i_pop_ready;
    assign o_valid = r_main_valid;
    assign o_item  = r_main;
    // New items are taken as long as the skid entry is free.
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_item;
            end
        end else if (i_push) begin
            r_skid <= i_item;
        end
    end

    // The skid entry is only ever filled behind a held main entry.
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry valid with empty main register");

    // Nothing may be pushed while the skid entry is occupied.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("push into full output stage");

    // A stalled main entry keeps its contents.
    a_main_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_valid && !i_pop_ready) |=> (r_main_valid && $stable(r_main)))
        else $error("main output register changed while stalled");

endmodule

FILE: rtl/usb_midi_event_packet_encoder.sv
// Top level of the USB-MIDI event packet encoder (cable 0).
// Depends on umepe_pkg and instantiates umepe_out_stage.
`timescale 1ns / 1ps

// A result item is registered in the output stage. Throughput: one input byte per
// cycle while tready is high; the per-byte work is a few compares and muxes.
// Output stalls are absorbed by a one-entry skid, so tready drops only after two
// results are held back by the downstream side.
// Reset (synchronous, active low) closes any open message, clears the packet count
// and empties the output stage.

module usb_midi_event_packet_encoder #(
    parameter int unsigned MAX_PACKETS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side: one MIDI byte per item.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] midi_byte
    input  logic        i_s_tlast,   // last_byte of the transfer
    // Master side: one event packet or bare end marker per item.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [umepe_pkg::OUT_TDATA_W-1:0] o_m_tdata,
        // [3:0] code_index, [11:4] status_byte, [19:12] data_one,
        // [27:20] data_two, [31:28] zero
    output logic        o_m_tuser,   // has_packet
    output logic        o_m_tlast    // transfer_end
);
    import umepe_pkg::*;

    // The packet counter has to hold MAX_PACKETS itself.
    localparam int unsigned CNT_W = $clog2(MAX_PACKETS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKETS);

    // Message assembly state.
    t_pend            r_pending, n_pending;
    logic [7:0]       r_status, n_status;
    logic [3:0]       r_code, n_code;
    logic [7:0]       r_first, n_first;
    logic [CNT_W-1:0] r_pkt_count, n_pkt_count;

    logic    s_accept;
    logic    push;
    t_result result;
    t_result m_item;

    logic    have;
    logic    is_status;
    logic [3:0] hi_nib;

    assign s_accept  = i_s_tvalid && o_s_tready;
    assign hi_nib    = i_s_tdata[7:4];
    assign is_status = i_s_tdata[7];

    // Per-byte decode: any byte fills the open message, a status byte with no
    // message open starts one (subject to the per-transfer packet limit), and the
    // last byte of a transfer always yields a result, flushing any truncated message.
    always_comb begin
        n_pending   = r_pending;
        n_status    = r_status;
        n_code      = r_code;
        n_first     = r_first;
        n_pkt_count = r_pkt_count;
        have        = 1'b0;
        result      = '0;

        case (r_pending)
            PEND_TWO: begin
                n_first   = i_s_tdata;
                n_pending = PEND_ONE;
            end
            PEND_ONE: begin
                n_pending          = PEND_NONE;
                have               = 1'b1;
                result.has_packet  = 1'b1;
                result.code_index  = r_code;
                result.status_byte = r_status;
                if (r_code == CIN_PROG_CHANGE || r_code == CIN_CHAN_PRESS) begin
                    result.data_one = i_s_tdata;
                end else begin
                    result.data_one = r_first;
                    result.data_two = i_s_tdata;
                end
            end
            PEND_NONE: begin
                if (is_status && (r_pkt_count < CNT_MAX)) begin
                    n_pkt_count = r_pkt_count + CNT_W'(1);
                    n_status    = i_s_tdata;
                    n_first     = 8'h00;
                    n_code      = hi_nib;
                    case (hi_nib)
                        CIN_SYSTEM: begin
                            // System bytes are sent as one-byte messages.
                            have               = 1'b1;
                            result.has_packet  = 1'b1;
                            result.code_index  = CIN_SYSTEM;
                            result.status_byte = i_s_tdata;
                        end
                        CIN_PROG_CHANGE, CIN_CHAN_PRESS: begin
                            n_pending = PEND_ONE;
                        end
                        default: begin
                            n_pending = PEND_TWO;
                        end
                    endcase
                end
            end
            default: begin
                n_pending = PEND_NONE;
            end
        endcase

        if (i_s_tlast) begin
            if (!have) begin
                if (n_pending != PEND_NONE) begin
                    // Message cut off by the end of the transfer: missing bytes are zero.
                    result.has_packet  = 1'b1;
                    result.code_index  = n_code;
                    result.status_byte = n_status;
                    result.data_one    = n_first;
                    result.data_two    = 8'h00;
                end else begin
                    result = '0;
                end
            end
            result.transfer_end = 1'b1;
            n_pending           = PEND_NONE;
            n_pkt_count         = '0;
        end
    end

    assign push = s_accept && (have || i_s_tlast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= PEND_NONE;
            r_status    <= 8'h00;
            r_code      <= 4'h0;
            r_first     <= 8'h00;
            r_pkt_count <= '0;
        end else if (s_accept) begin
            r_pending   <= n_pending;
            r_status    <= n_status;
            r_code      <= n_code;
            r_first     <= n_first;
            r_pkt_count <= n_pkt_count;
        end
    end

    umepe_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (result),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .i_pop_ready (i_m_tready),
        .o_item      (m_item)
    );

    assign o_m_tdata = {4'h0, m_item.data_two, m_item.data_one,
                        m_item.status_byte, m_item.code_index};
    assign o_m_tuser = m_item.has_packet;
    assign o_m_tlast = m_item.transfer_end;

    // The number of messages started never passes the per-transfer limit.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pkt_count <= CNT_MAX)
        else $error("packet count above limit");

    // The last byte of a transfer closes any message and restarts the count.
    a_transfer_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tlast) |=> (r_pending == PEND_NONE && r_pkt_count == '0))
        else $error("state not cleared at transfer end");

    // A bare end marker carries an all-zero payload.
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !result.has_packet) |->
            (result.transfer_end && result.code_index == 4'h0 &&
             result.status_byte == 8'h00 && result.data_one == 8'h00 &&
             result.data_two == 8'h00))
        else $error("end marker with nonzero payload");

    // Every accepted last byte produces a result.
    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tlast) |-> push)
        else $error("transfer end produced no result");

endmodule

FILE: tb/sv/usb_midi_event_packet_encoder_tb.sv
// Self-checking testbench for the USB-MIDI event packet encoder (cable 0).
// Depends on umepe_pkg and usb_midi_event_packet_encoder, which instantiates umepe_out_stage.
// Directed rows, some with typed results, then random transfers; a predictor checks the rest.
`timescale 1ns / 1ps

module usb_midi_event_packet_encoder_tb;

    import umepe_pkg::*;

    // The block is built with its default packet limit, and the predictor uses the same value.
    localparam int unsigned PKT_LIMIT    = 16;
    // Random stimulus stops once this many random bytes are planned.
    localparam int unsigned RAND_ITEMS   = 950;
    // The receiver holds off once this many bytes are in; HOLD_CYCLES sets for how long.
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned HOLD_CYCLES  = 60;
    // The sender waits for every expected packet before this item.
    localparam int unsigned PAUSE_AT     = 600;
    // The last bytes of the run go through with no idling on either side.
    localparam int unsigned TAIL_ITEMS   = 120;

    // One planned input byte. Rows with typed set carry their expected result in
    // exp_pkt; want says whether that row gives a result at all.
    typedef struct packed {
        logic [7:0] midi_byte;
        logic       last_byte;
        logic       typed;
        logic       want;
        t_result    exp_pkt;
    } t_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] midi_byte
    logic        i_s_tlast  = 1'b0;    // last_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
        // [3:0] code_index, [11:4] status_byte, [19:12] data_one,
        // [27:20] data_two, [31:28] zero
    logic        o_m_tuser;            // has_packet
    logic        o_m_tlast;            // transfer_end

    usb_midi_event_packet_encoder #(
        .MAX_PACKETS (PKT_LIMIT)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Encoder state as the predictor sees it.
    t_pend       msg_pend     = PEND_NONE;
    logic [7:0]  msg_status   = 8'h00;
    logic [3:0]  msg_code     = 4'h0;
    logic [7:0]  msg_first    = 8'h00;
    int unsigned msgs_started = 0;

    t_row        byte_plan[$];     // every byte of the run, directed rows first
    t_result     packets_due[$];   // expected output items, oldest first
    int unsigned n_accepted   = 0;
    int unsigned n_checked    = 0;
    int unsigned n_markers    = 0;
    int unsigned n_truncated  = 0;
    int unsigned n_limited    = 0;
    int unsigned n_errors     = 0;
    bit          send_done    = 1'b0;

    function automatic t_result pkt(input logic has, input logic [3:0] cin,
                                    input logic [7:0] st, input logic [7:0] d1,
                                    input logic [7:0] d2, input logic fin);
        t_result r;
        r.has_packet   = has;
        r.code_index   = cin;
        r.status_byte  = st;
        r.data_one     = d1;
        r.data_two     = d2;
        r.transfer_end = fin;
        return r;
    endfunction

    function automatic t_row mk_row(input logic [7:0] b, input logic lst, input logic typed,
                                    input logic want, input t_result r);
        t_row row;
        row.midi_byte = b;
        row.last_byte = lst;
        row.typed     = typed;
        row.want      = want;
        row.exp_pkt   = r;
        return row;
    endfunction

    // Packs one MIDI byte into the running message and tells whether an output
    // item results. A transfer end always yields an item: the packet that the
    // byte completes, a truncated packet, or a bare end marker.
    task automatic encode_byte(input logic [7:0] b, input logic lst,
                               output bit got, output t_result r);
        got = 1'b0;
        r   = '0;
        case (msg_pend)
            PEND_TWO: begin
                msg_first = b;
                msg_pend  = PEND_ONE;
            end
            PEND_ONE: begin
                // Any byte in a data position is data, even with its top bit set.
                msg_pend = PEND_NONE;
                got      = 1'b1;
                if (msg_code == CIN_PROG_CHANGE || msg_code == CIN_CHAN_PRESS) begin
                    r = pkt(1'b1, msg_code, msg_status, b, 8'h00, lst);
                end else begin
                    r = pkt(1'b1, msg_code, msg_status, msg_first, b, lst);
                end
            end
            default: begin
                if (b[7] && msgs_started < PKT_LIMIT) begin
                    msgs_started++;
                    msg_status = b;
                    msg_first  = 8'h00;
                    if (b[7:4] == CIN_SYSTEM) begin
                        msg_code = CIN_SYSTEM;
                        got      = 1'b1;
                        r        = pkt(1'b1, CIN_SYSTEM, b, 8'h00, 8'h00, lst);
                    end else if (b[7:4] == CIN_PROG_CHANGE || b[7:4] == CIN_CHAN_PRESS) begin
                        msg_code = b[7:4];
                        msg_pend = PEND_ONE;
                    end else begin
                        msg_code = b[7:4];
                        msg_pend = PEND_TWO;
                    end
                end else if (b[7]) begin
                    // Status byte past the per-transfer packet limit.
                    n_limited++;
                end
                // A data byte with no open message is skipped.
            end
        endcase
        if (lst) begin
            if (!got) begin
                got = 1'b1;
                if (msg_pend != PEND_NONE) begin
                    r = pkt(1'b1, msg_code, msg_status, msg_first, 8'h00, 1'b1);
                    n_truncated++;
                end else begin
                    r = pkt(1'b0, 4'h0, 8'h00, 8'h00, 8'h00, 1'b1);
                end
            end
            msg_pend     = PEND_NONE;
            msgs_started = 0;
        end
    endtask

    // Plans one random transfer. Most messages are well formed with random
    // content; some bytes are strays or arbitrary, the last message is sometimes
    // cut short, and now and then a transfer carries more messages than the limit.
    task automatic plan_transfer();
        logic [7:0] seq[$];
        int         n_msgs;
        int         n_data;
        int         sel;
        logic [3:0] nib;
        n_msgs = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
        for (int m = 0; m < n_msgs; m++) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                seq.push_back(8'($urandom_range(0, 127)));
            end else if (sel == 1) begin
                seq.push_back(8'($urandom_range(0, 255)));
            end else begin
                nib = 4'($urandom_range(8, 15));
                seq.push_back({nib, 4'($urandom_range(0, 15))});
                if (nib == CIN_SYSTEM) begin
                    n_data = 0;
                end else if (nib == CIN_PROG_CHANGE || nib == CIN_CHAN_PRESS) begin
                    n_data = 1;
                end else begin
                    n_data = 2;
                end
                if (m == n_msgs - 1 && n_data > 0 && $urandom_range(0, 3) == 0) begin
                    n_data--;
                end
                for (int d = 0; d < n_data; d++) begin
                    seq.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                                               : 8'($urandom_range(0, 127)));
                end
            end
        end
        foreach (seq[i]) begin
            byte_plan.push_back(mk_row(seq[i], i == seq.size() - 1, 1'b0, 1'b0, '0));
        end
    endtask

    // Compares one output item with the oldest expectation.
    task automatic check_result();
        t_result want;
        t_result got;
        got.has_packet   = o_m_tuser;
        got.code_index   = o_m_tdata[3:0];
        got.status_byte  = o_m_tdata[11:4];
        got.data_one     = o_m_tdata[19:12];
        got.data_two     = o_m_tdata[27:20];
        got.transfer_end = o_m_tlast;
        if (packets_due.size() == 0) begin
            $error("output item with nothing expected: tdata=%h tuser=%b tlast=%b",
                   o_m_tdata, o_m_tuser, o_m_tlast);
            n_errors++;
        end else begin
            want = packets_due.pop_front();
            n_checked++;
            if (!want.has_packet) n_markers++;
            if (got.has_packet !== want.has_packet) begin
                $error("has_packet: expected %0d, got %0d", want.has_packet, got.has_packet);
                n_errors++;
            end
            if (got.code_index !== want.code_index) begin
                $error("code_index: expected %h, got %h", want.code_index, got.code_index);
                n_errors++;
            end
            if (got.status_byte !== want.status_byte) begin
                $error("status_byte: expected %h, got %h", want.status_byte, got.status_byte);
                n_errors++;
            end
            if (got.data_one !== want.data_one) begin
                $error("data_one: expected %h, got %h", want.data_one, got.data_one);
                n_errors++;
            end
            if (got.data_two !== want.data_two) begin
                $error("data_two: expected %h, got %h", want.data_two, got.data_two);
                n_errors++;
            end
            if (got.transfer_end !== want.transfer_end) begin
                $error("transfer_end: expected %0d, got %0d",
                       want.transfer_end, got.transfer_end);
                n_errors++;
            end
        end
    endtask

    // Sender: builds the plan, releases reset, then offers every byte in turn.
    initial begin
        int unsigned n_plan;
        int unsigned gap;
        bit          calm;
        bit          got;
        t_result     r;

        // Directed part. It opens right after reset with stray data bytes, walks
        // every code index from 8 to F, puts bytes with the top bit set into data positions,
        // and ends transfers on complete, truncated and empty messages.
        byte_plan.push_back(mk_row(8'h00, 1'b0, 1'b1, 1'b0, '0));
        byte_plan.push_back(mk_row(8'h7F, 1'b1, 1'b1, 1'b1,
                                   pkt(1'b0, 4'h0, 8'h00, 8'h00, 8'h00, 1'b1)));
        byte_plan.push_back(mk_row(8'h90, 1'b0, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'h3C, 1'b0, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'h7F, 1'b0, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'h80, 1'b0, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'h00, 1'b0, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'hC5, 1'b0, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'h80, 1'b0, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'hDF, 1'b0, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'h7F, 1'b0, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'hF8, 1'b0, 1'b1, 1'b1,
                                   pkt(1'b1, CIN_SYSTEM, 8'hF8, 8'h00, 8'h00, 1'b0)));
        byte_plan.push_back(mk_row(8'hFF, 1'b1, 1'b1, 1'b1,
                                   pkt(1'b1, CIN_SYSTEM, 8'hFF, 8'h00, 8'h00, 1'b1)));
        byte_plan.push_back(mk_row(8'hE0, 1'b0, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'h12, 1'b1, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'hB3, 1'b1, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'hA0, 1'b0, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'h01, 1'b0, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'h02, 1'b1, 1'b0, 1'b0, '0));
        byte_plan.push_back(mk_row(8'hC0, 1'b1, 1'b1, 1'b1,
                                   pkt(1'b1, CIN_PROG_CHANGE, 8'hC0, 8'h00, 8'h00, 1'b1)));
        n_plan = byte_plan.size() + RAND_ITEMS;
        while (byte_plan.size() < n_plan) plan_transfer();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        calm = 1'b0;
        foreach (byte_plan[k]) begin
            // Idle bursts come at random, but not during the receiver's long
            // hold-off (so the block fills up and stalls its input), not in a
            // calm stretch, and not near the end of the run.
            if ($urandom_range(0, 39) == 0) calm = !calm;
            gap = 0;
            if (!calm && k + TAIL_ITEMS < byte_plan.size()
                && !(n_accepted >= HOLD_AT && n_accepted < HOLD_AT + 100)
                && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 12);
            end
            if (k == PAUSE_AT) begin
                // Let the block drain completely before going on.
                i_s_tvalid <= 1'b0;
                do @(posedge i_clk); while (packets_due.size() != 0);
            end else if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= byte_plan[k].midi_byte;
            i_s_tlast  <= byte_plan[k].last_byte;
            do @(posedge i_clk); while (!o_s_tready);

            encode_byte(byte_plan[k].midi_byte, byte_plan[k].last_byte, got, r);
            if (byte_plan[k].typed) begin
                if (byte_plan[k].want) packets_due.push_back(byte_plan[k].exp_pkt);
            end else if (got) begin
                packets_due.push_back(r);
            end
            n_accepted++;
        end
        i_s_tvalid <= 1'b0;
        send_done = 1'b1;

        // Wait for the last expected item, then go on clocking so that any
        // spurious extra item would still be seen.
        while (packets_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d MIDI bytes; checked %0d items (%0d end markers, %0d truncated).",
                 n_accepted, n_checked, n_markers, n_truncated);
        $display("Status bytes dropped at the packet limit: %0d; mismatches: %0d.",
                 n_limited, n_errors);
        if (n_errors == 0) begin
            $display("usb_midi_event_packet_encoder_tb OK");
        end else begin
            $display("usb_midi_event_packet_encoder_tb NOT OK");
        end
        $finish;
    end

    // Receiver: checks every output item and drives tready with random stall
    // bursts, one long hold-off, calm stretches, and no stalls near the end.
    initial begin
        int unsigned stall_left;
        bit          held;
        bit          calm;
        stall_left = 0;
        held       = 1'b0;
        calm       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) check_result();
            if ($urandom_range(0, 63) == 0) calm = !calm;
            if (!held && n_accepted >= HOLD_AT) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (send_done || calm || n_accepted + TAIL_ITEMS >= byte_plan.size()) begin
                i_m_tready <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #1000000;
        $display("usb_midi_event_packet_encoder_tb NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/umepe_pkg.sv
rtl/umepe_out_stage.sv
rtl/usb_midi_event_packet_encoder.sv
tb/sv/usb_midi_event_packet_encoder_tb.sv
